FILE: rtl/core/pdl_pkg.sv
// ----------------------------------------------------------------------------
// Pump drive level package
// Shared types, constants and arithmetic helpers for the pump drive level.
// ----------------------------------------------------------------------------
package pdl_pkg;

  localparam int unsigned FIELD_W = 12;
  localparam int unsigned ACC_W   = 36;
  localparam int unsigned DEN_W   = 40;
  localparam int unsigned QUO_W   = 16;
  localparam int unsigned FRAC_W  = 17;
  localparam int unsigned MCPS_W  = 7;
  localparam int unsigned FPC_W   = 16;

  localparam logic [FRAC_W-1:0] FULL_FRAC = 17'h10000;
  localparam int unsigned PUMP_LEVEL_RANGE_DEF = 100;
  localparam logic [MCPS_W-1:0] MCPS_RESET = 7'd50;
  localparam logic [FPC_W-1:0]  FPC0_RESET = 16'd19005;

  localparam logic CFG_MCPS = 1'b0;
  localparam logic CFG_FPC0 = 1'b1;

  typedef enum logic {
    KIND_PRESSURE,
    KIND_FLOW
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] target;
    logic [FIELD_W-1:0] limit;
    logic [FIELD_W-1:0] pressure;
    logic [FIELD_W-1:0] flow;
    logic               falling;
  } job_t;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [QUO_W-1:0] quo;
  } div_res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_POLY,
    B_DEN,
    B_START,
    B_DIV,
    B_SEL,
    B_FRAC,
    B_LVL
  } back_state_t;

  function automatic logic signed [ACC_W-1:0] coef(input logic [2:0] idx,
                                                  input logic [FPC_W-1:0] fpc0);
    logic signed [ACC_W-1:0] c;
    case (idx)
      3'd6: c = 36'sd80;
      3'd5: c = -36'sd3427;
      3'd4: c = 36'sd25512;
      3'd3: c = 36'sd392990;
      3'd2: c = -36'sd7902740;
      3'd1: c = 36'sd9534827;
      3'd0: c = $signed({4'b0, fpc0, 16'b0}) - 36'sd549755814;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Exact floor(x / 5) for x below 2^21 by a reciprocal multiply.
  function automatic logic [18:0] div5(input logic [20:0] x);
    logic [41:0] prod;
    prod = {21'b0, x} * {21'b0, 21'd1677722};
    return prod[41:23];
  endfunction

endpackage

FILE: rtl/core/pump_drive_level.sv
// ----------------------------------------------------------------------------
// Pump drive level
// Drive level for a vibratory pump from mode, target, limit and measurements.
// ----------------------------------------------------------------------------
// Each request yields one level transaction after the back end picks it up:
// a pickup step, Horner evaluation of the polynomial, divisor setup and
// divider start, the two parallel restoring dividers up to their done flag,
// and then rule selection, limiting and scaling. The back end takes a new
// request only after it has loaded the level for the last one, so the divider
// loop dominates its throughput. A stalled output holds the back end in its
// last step. A two-entry queue lets requests be taken while earlier ones are
// in work.
module pump_drive_level #(
  parameter int unsigned PUMP_LEVEL_RANGE = pdl_pkg::PUMP_LEVEL_RANGE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [55:0]                  s_tdata,   // target_value, restriction_value,
                                                  // measured_pressure, measured_flow,
                                                  // pressure_falling
  input  logic                         s_tuser,   // req_type
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,   // pump_level
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [15:0]                  cfg_data
);
  import pdl_pkg::*;

  logic [MCPS_W-1:0] mcps;
  logic [FPC_W-1:0]  fpc0;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  job_t              push_job;
  job_t              pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mcps <= MCPS_RESET;
      fpc0 <= FPC0_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MCPS: mcps <= cfg_data[MCPS_W-1:0];
        CFG_FPC0: fpc0 <= cfg_data;
        default: ;
      endcase
    end
  end

  pdl_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (full),
    .q_push   (push),
    .q_job    (push_job)
  );

  pdl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (full),
    .empty    (empty)
  );

  pdl_back #(
    .PUMP_LEVEL_RANGE (PUMP_LEVEL_RANGE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (empty),
    .q_job    (pop_job),
    .q_pop    (pop),
    .mcps     (mcps),
    .fpc0     (fpc0),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: rtl/core/pdl_front.sv
// ----------------------------------------------------------------------------
// Pump drive level front end
// Accepts request transactions and classifies them into jobs for the queue.
// ----------------------------------------------------------------------------
module pdl_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [55:0]       s_tdata,   // target, restriction, pressure, flow, falling
  input  logic              s_tuser,   // req_type
  input  logic              q_full,
  output logic              q_push,
  output pdl_pkg::job_t     q_job
);
  import pdl_pkg::*;

  logic [FIELD_W-1:0] target;
  logic [FIELD_W-1:0] restr;
  logic [FIELD_W-1:0] press;
  logic               limit_hit;

  assign target    = s_tdata[11:0];
  assign restr     = s_tdata[23:12];
  assign press     = s_tdata[35:24];
  assign limit_hit = (restr != '0) && ({press, 1'b0} > {1'b0, restr});

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_job.pressure = press;
    q_job.flow     = s_tdata[47:36];
    q_job.falling  = s_tdata[48];
    if (s_tuser && !limit_hit) begin
      q_job.kind   = KIND_FLOW;
      q_job.target = target;
      q_job.limit  = '0;
    end else if (s_tuser) begin
      q_job.kind   = KIND_PRESSURE;
      q_job.target = restr;
      q_job.limit  = target;
    end else begin
      q_job.kind   = KIND_PRESSURE;
      q_job.target = target;
      q_job.limit  = restr;
    end
  end

endmodule

FILE: rtl/core/pdl_fifo.sv
// ----------------------------------------------------------------------------
// Pump drive level job queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pdl_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pdl_pkg::job_t push_job,
  input  logic          pop,
  output pdl_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);
  import pdl_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/core/pdl_div.sv
// ----------------------------------------------------------------------------
// Pump drive level divider
// Restoring divider giving floor(q * 2^40 / den) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdl_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pdl_pkg::FIELD_W-1:0]   q,
  input  logic [pdl_pkg::DEN_W-1:0]     den,
  output pdl_pkg::div_res_t             res
);
  import pdl_pkg::*;

  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem2;
  logic [DEN_W-1:0] num_hi;
  logic [4:0]       cnt;
  logic             busy;
  logic             take;
  logic             sat;
  logic             done;
  logic [QUO_W-1:0] quo;

  assign num_hi = {{(DEN_W-FIELD_W-24){1'b0}}, q, 24'b0};
  assign rem2   = {rem, 1'b0};
  assign take   = (rem2 >= {1'b0, den});
  assign res    = {done, sat, quo};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num_hi;
      sat <= (num_hi >= den);
    end else if (busy) begin
      rem <= take ? DEN_W'(rem2 - {1'b0, den}) : rem2[DEN_W-1:0];
      quo <= {quo[QUO_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/pdl_back.sv
// ----------------------------------------------------------------------------
// Pump drive level back end
// Evaluates the flow-per-click polynomial, divides and applies the drive rule.
// ----------------------------------------------------------------------------
module pdl_back #(
  parameter int unsigned PUMP_LEVEL_RANGE = pdl_pkg::PUMP_LEVEL_RANGE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  pdl_pkg::job_t               q_job,
  output logic                        q_pop,
  input  logic [pdl_pkg::MCPS_W-1:0]  mcps,
  input  logic [pdl_pkg::FPC_W-1:0]   fpc0,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata    // pump_level
);
  import pdl_pkg::*;

  localparam int unsigned LEVEL_W = $clog2(PUMP_LEVEL_RANGE + 1);

  back_state_t state, state_next;
  job_t                    job;
  logic [2:0]              idx;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W+12:0] prod;
  logic signed [ACC_W+12:0] prod_adj;
  logic signed [ACC_W+12:0] prod_sh;
  logic [DEN_W-1:0]        den;
  logic                    acc_pos;
  logic                    div_start;
  logic                    out_load;
  div_res_t                res_a;
  div_res_t                res_b;
  logic [FRAC_W-1:0]       frac_a;
  logic [FRAC_W-1:0]       frac_b;
  logic signed [12:0]      d;
  logic [21:0]             m19;
  logic [21:0]             near_sum;
  logic [20:0]             x;
  logic [20:0]             x_next;
  logic                    use_div;
  logic                    use_div_next;
  logic [FRAC_W-1:0]       direct;
  logic [FRAC_W-1:0]       direct_next;
  logic [FRAC_W-1:0]       cap;
  logic [FRAC_W-1:0]       cap_next;
  logic [18:0]             cand;
  logic [FRAC_W-1:0]       frac;
  logic [FRAC_W+LEVEL_W-1:0] scaled;

  pdl_div u_div_a (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .q     ((job.kind == KIND_FLOW) ? job.target : job.limit),
    .den   (den),
    .res   (res_a)
  );

  pdl_div u_div_b (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .q     (job.flow),
    .den   (den),
    .res   (res_b)
  );

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!q_empty) state_next = B_POLY;
      B_POLY:  if (idx == 3'd0) state_next = B_DEN;
      B_DEN:   state_next = B_START;
      B_START: state_next = B_DIV;
      B_DIV:   if (res_a.done) state_next = B_SEL;
      B_SEL:   state_next = B_FRAC;
      B_FRAC:  state_next = B_LVL;
      B_LVL:   if (!m_tvalid || m_tready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      B_IDLE:  q_pop = !q_empty;
      B_START: div_start = 1'b1;
      B_LVL:   out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Horner step with truncation toward zero.
  assign prod     = acc * $signed({1'b0, job.pressure});
  assign prod_adj = prod + (prod[ACC_W+12] ? (ACC_W+13)'(255) : '0);
  assign prod_sh  = prod_adj >>> 8;

  always_comb begin
    if (mcps == '0) begin
      frac_a = '0;
      frac_b = '0;
    end else if (!acc_pos) begin
      frac_a = FULL_FRAC;
      frac_b = FULL_FRAC;
    end else begin
      frac_a = res_a.sat ? FULL_FRAC : {1'b0, res_a.quo};
      frac_b = res_b.sat ? FULL_FRAC : {1'b0, res_b.quo};
    end
  end

  assign d        = $signed({1'b0, job.target}) - $signed({1'b0, job.pressure});
  assign m19      = ({5'b0, frac_b} << 4) + ({5'b0, frac_b} << 1) + {5'b0, frac_b};
  assign near_sum = m19 + 22'd131072 + {2'b0, d[9:0], 10'b0};

  always_comb begin
    x_next       = '0;
    use_div_next = 1'b0;
    direct_next  = '0;
    cap_next     = (job.limit == '0) ? FULL_FRAC : frac_a;
    if (job.kind == KIND_FLOW) begin
      cap_next    = FULL_FRAC;
      direct_next = frac_a;
    end else if (job.target == '0) begin
      direct_next = '0;
    end else if (d > 13'sd512) begin
      use_div_next = 1'b1;
      x_next       = 21'd81920 + {1'b0, d[11:0], 8'b0};
    end else if (d > 13'sd0) begin
      use_div_next = 1'b1;
      x_next       = {1'b0, near_sum[21:2]};
    end else if (job.falling) begin
      direct_next = {1'b0, frac_b[FRAC_W-1:1]};
    end
  end

  assign cand   = use_div ? div5(x) : {2'b0, direct};
  assign scaled = {{LEVEL_W{1'b0}}, frac} * {{FRAC_W{1'b0}}, LEVEL_W'(PUMP_LEVEL_RANGE)};

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          job <= q_job;
          acc <= '0;
          idx <= 3'd6;
        end
      end
      B_POLY: begin
        acc <= prod_sh[ACC_W-1:0] + coef(idx, fpc0);
        idx <= idx - 3'd1;
      end
      B_DEN: begin
        den     <= DEN_W'({6'b0, acc[ACC_W-2:0]} * {35'b0, 6'd50});
        acc_pos <= !acc[ACC_W-1] && (acc != '0);
      end
      B_SEL: begin
        x       <= x_next;
        use_div <= use_div_next;
        direct  <= direct_next;
        cap     <= cap_next;
      end
      B_FRAC: begin
        frac <= ({2'b0, cap} < cand) ? cap : cand[FRAC_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= 8'(scaled[16 +: LEVEL_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
